// ===== rtl/lap_pkg.sv =====
// ----------------------------------------------------------------------------
// lap_pkg
// Shared types and constants of the five-point Laplacian stencil.
// ----------------------------------------------------------------------------
package lap_pkg;

   localparam int DATA_W = 32;   // Q16.16 sample and result width
   localparam int D2_W   = 35;   // exact second difference of three samples
   localparam int DIM_W  = 9;    // grid_width and grid_height registers
   localparam int COEF_W = 32;   // unsigned Q16.16 coefficients
   localparam int IDX_W  = 8;    // configuration register index
   localparam int POS_W  = 8;    // row and column of a result
   localparam int FRAC_W = 16;   // fraction bits of Q16.16

   localparam logic [DIM_W-1:0]  GRID_DIM_RESET = 9'd8;
   localparam logic [COEF_W-1:0] COEF_RESET     = 32'h0001_0000;

   typedef enum logic [IDX_W-1:0] {
      CSR_GRID_WIDTH  = 8'd0,
      CSR_GRID_HEIGHT = 8'd1,
      CSR_COEF_X      = 8'd2,
      CSR_COEF_Y      = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]  grid_width;
      logic [DIM_W-1:0]  grid_height;
      logic [COEF_W-1:0] coef_x;
      logic [COEF_W-1:0] coef_y;
   } lap_cfg_type;

   typedef struct packed {
      logic             last;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } lap_meta_type;

endpackage

// ===== rtl/lap_csr.sv =====
// ----------------------------------------------------------------------------
// lap_csr
// Configuration registers: grid size and the two inverse-spacing coefficients.
// ----------------------------------------------------------------------------
module lap_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lap_pkg::IDX_W-1:0] csr_index,
   input  logic [lap_pkg::DATA_W-1:0] csr_data,
   output lap_pkg::lap_cfg_type      cfg
);
   import lap_pkg::*;

   lap_cfg_type cfg_ff;
   lap_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         // Writes to an index outside the register list are dropped.
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_data[DIM_W-1:0];
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_data[DIM_W-1:0];
            CSR_COEF_X:      cfg_in.coef_x      = csr_data[COEF_W-1:0];
            CSR_COEF_Y:      cfg_in.coef_y      = csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GRID_DIM_RESET;
         cfg_ff.grid_height <= GRID_DIM_RESET;
         cfg_ff.coef_x      <= COEF_RESET;
         cfg_ff.coef_y      <= COEF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/lap_line_buf.sv =====
// ----------------------------------------------------------------------------
// lap_line_buf
// Raster counters and the two line memories. Each sample reads the previous
// two padded rows, writes itself back, and forms both second differences.
// ----------------------------------------------------------------------------
module lap_line_buf #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lap_pkg::lap_cfg_type              cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lap_pkg::DATA_W-1:0]        req_tdata,
   output logic                              d_valid,
   input  logic                              d_ready,
   output logic signed [lap_pkg::D2_W-1:0]   d2x,
   output logic signed [lap_pkg::D2_W-1:0]   d2y,
   output lap_pkg::lap_meta_type             d_meta
);
   import lap_pkg::*;

   localparam int DEPTH = MAX_WIDTH + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH + 3);
   localparam int RW    = $clog2(MAX_HEIGHT + 3);

   logic [DATA_W-1:0] above_mem     [DEPTH];
   logic [DATA_W-1:0] two_above_mem [DEPTH];

   logic [CW-1:0] pad_w;
   logic [RW-1:0] pad_h;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW:0]   col_next;
   logic [RW:0]   row_next;
   logic          col_wrap;
   logic          row_wrap;
   logic          accept;
   logic          emit;
   logic [RW-1:0] row_off;
   logic [CW-1:0] col_off;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] east_addr;
   lap_meta_type  meta;

   logic [DATA_W-1:0] centre_ff, east_ff, north_ff, west_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_emit_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic [DATA_W-1:0] s1_sample_ff;
   lap_meta_type      s1_meta_ff;
   logic              s1_adv;

   logic signed [D2_W-1:0] c_ext, e_ext, w_ext, n_ext, s_ext;

   // Padded extents; a zero size acts as one, an oversize one as the maximum.
   always_comb begin
      if (cfg.grid_width == '0) begin
         pad_w = CW'(3);
      end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
         pad_w = CW'(MAX_WIDTH + 2);
      end else begin
         pad_w = CW'(cfg.grid_width) + CW'(2);
      end
      if (cfg.grid_height == '0) begin
         pad_h = RW'(3);
      end else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) begin
         pad_h = RW'(MAX_HEIGHT + 2);
      end else begin
         pad_h = RW'(cfg.grid_height) + RW'(2);
      end
   end

   assign col_next = {1'b0, col_ff} + (CW+1)'(1);
   assign row_next = {1'b0, row_ff} + (RW+1)'(1);
   assign col_wrap = col_next >= {1'b0, pad_w};
   assign row_wrap = row_next >= {1'b0, pad_h};

   assign s1_adv     = s1_valid_ff && (!s1_emit_ff || d_ready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // An interior point is complete once the sample south of it arrives.
   assign emit = (row_ff >= RW'(2)) && (row_ff < pad_h) && (col_ff != '0) && !col_wrap;

   assign row_off   = row_ff - RW'(2);
   assign col_off   = col_ff - CW'(1);
   assign meta.row  = POS_W'(row_off);
   assign meta.col  = POS_W'(col_off);
   assign meta.last = (row_next == {1'b0, pad_h}) && ((col_next + (CW+1)'(1)) == {1'b0, pad_w});

   assign rd_addr   = col_ff[AW-1:0];
   assign east_addr = (col_next < (CW+1)'(DEPTH)) ? col_next[AW-1:0] : col_ff[AW-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Row r-1: read the centre and east taps, then replace the centre with
   // the new sample. The read returns the value held before this write.
   always_ff @(posedge clock) begin
      if (accept) begin
         centre_ff          <= above_mem[rd_addr];
         east_ff            <= above_mem[east_addr];
         above_mem[rd_addr] <= req_tdata;
      end
   end

   // Row r-2: the old centre moves down one row when its item leaves stage 1.
   always_ff @(posedge clock) begin
      if (accept) begin
         north_ff <= two_above_mem[rd_addr];
      end
      if (s1_adv) begin
         two_above_mem[s1_addr_ff] <= centre_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff   <= emit;
         s1_addr_ff   <= rd_addr;
         s1_sample_ff <= req_tdata;
         s1_meta_ff   <= meta;
      end
      if (s1_adv) begin
         west_ff <= centre_ff;
      end
   end

   assign c_ext = D2_W'(signed'(centre_ff));
   assign e_ext = D2_W'(signed'(east_ff));
   assign w_ext = D2_W'(signed'(west_ff));
   assign n_ext = D2_W'(signed'(north_ff));
   assign s_ext = D2_W'(signed'(s1_sample_ff));

   assign d2x     = e_ext - (c_ext <<< 1) + w_ext;
   assign d2y     = s_ext - (c_ext <<< 1) + n_ext;
   assign d_valid = s1_valid_ff && s1_emit_ff;
   assign d_meta  = s1_meta_ff;

endmodule

// ===== rtl/lap_scale.sv =====
// ----------------------------------------------------------------------------
// lap_scale
// Weights the second differences by the coefficients, drops 16 fraction
// bits with floor rounding and saturates to 32 bits. Holds the result.
// ----------------------------------------------------------------------------
module lap_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lap_pkg::COEF_W-1:0]       coef_x,
   input  logic [lap_pkg::COEF_W-1:0]       coef_y,
   input  logic                             d_valid,
   output logic                             d_ready,
   input  logic signed [lap_pkg::D2_W-1:0]  d2x,
   input  logic signed [lap_pkg::D2_W-1:0]  d2y,
   input  lap_pkg::lap_meta_type            d_meta,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lap_pkg::DATA_W-1:0]       laplacian,
   output lap_pkg::lap_meta_type            rsp_meta
);
   import lap_pkg::*;

   localparam int HALF_W = COEF_W / 2;
   localparam int P_W    = D2_W + HALF_W + 1;
   localparam int S_W    = P_W + 1;
   localparam int R_W    = S_W + 1;

   logic                   a_valid_ff, b_valid_ff, c_valid_ff, o_valid_ff;
   logic                   a_ready, b_ready, c_ready, o_ready;
   logic signed [D2_W-1:0] a_d2x_ff, a_d2y_ff;
   lap_meta_type           a_meta_ff, b_meta_ff, c_meta_ff, o_meta_ff;
   logic signed [P_W-1:0]  b_xhi_ff, b_xlo_ff, b_yhi_ff, b_ylo_ff;
   logic signed [S_W-1:0]  c_hi_ff, c_lo_ff;
   logic signed [R_W-1:0]  total;
   logic [R_W-DATA_W:0]    top_bits;
   logic [DATA_W-1:0]      sat_in;
   logic [DATA_W-1:0]      o_data_ff;

   logic signed [HALF_W:0] cx_hi, cx_lo, cy_hi, cy_lo;

   assign o_ready = !o_valid_ff || rsp_tready;
   assign c_ready = !c_valid_ff || o_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign d_ready = a_ready;

   assign cx_hi = signed'({1'b0, coef_x[COEF_W-1:HALF_W]});
   assign cx_lo = signed'({1'b0, coef_x[HALF_W-1:0]});
   assign cy_hi = signed'({1'b0, coef_y[COEF_W-1:HALF_W]});
   assign cy_lo = signed'({1'b0, coef_y[HALF_W-1:0]});

   // Integer and fraction halves of the product are summed apart; the
   // arithmetic shift of the fraction sum rounds toward minus infinity.
   assign total    = R_W'(c_hi_ff) + R_W'(c_lo_ff >>> FRAC_W);
   assign top_bits = total[R_W-1:DATA_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         sat_in = total[DATA_W-1:0];
      end else if (total[R_W-1]) begin
         sat_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= d_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && d_valid) begin
         a_d2x_ff  <= d2x;
         a_d2y_ff  <= d2y;
         a_meta_ff <= d_meta;
      end
      if (b_ready && a_valid_ff) begin
         b_xhi_ff  <= a_d2x_ff * cx_hi;
         b_xlo_ff  <= a_d2x_ff * cx_lo;
         b_yhi_ff  <= a_d2y_ff * cy_hi;
         b_ylo_ff  <= a_d2y_ff * cy_lo;
         b_meta_ff <= a_meta_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_hi_ff   <= S_W'(b_xhi_ff) + S_W'(b_yhi_ff);
         c_lo_ff   <= S_W'(b_xlo_ff) + S_W'(b_ylo_ff);
         c_meta_ff <= b_meta_ff;
      end
      if (o_ready && c_valid_ff) begin
         o_data_ff <= sat_in;
         o_meta_ff <= c_meta_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign laplacian  = o_data_ff;
   assign rsp_meta   = o_meta_ff;

endmodule

// ===== rtl/five_point_laplacian_stencil.sv =====
// ----------------------------------------------------------------------------
// five_point_laplacian_stencil
// Streaming five-point Laplacian over a ghost-padded grid in raster order.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req_    | in        | tdata[31:0] sample
//  rsp_    | out       | tdata[31:0] laplacian, [39:32] row, [47:40] col; tlast
//  csr_    | in        | index 0 grid_width, 1 grid_height, 2 coef_x, 3 coef_y
//
//  One sample is taken per clock unless a held result stalls the input; the
//  line memories are read and written back in a loop, one entry per sample, so nothing repeats.
//  From the sample south of its point, a result passes stage 1, then registers a, b, c and the output.
//  Reset is synchronous; the line memories are not cleared, so no clearing
//  pass is needed and a sample may be taken the cycle after reset.
//  A stalled result stops each stage only once the stage after it is full.
// ----------------------------------------------------------------------------
module five_point_laplacian_stencil #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] sample
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,   // [31:0] laplacian, [39:32] row, [47:40] col
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lap_pkg::IDX_W-1:0]  csr_index,
   input  logic [lap_pkg::DATA_W-1:0] csr_data
);
   import lap_pkg::*;

   lap_cfg_type            cfg;
   logic                   d_valid;
   logic                   d_ready;
   logic signed [D2_W-1:0] d2x;
   logic signed [D2_W-1:0] d2y;
   lap_meta_type           d_meta;
   lap_meta_type           rsp_meta;
   logic [DATA_W-1:0]      laplacian;

   lap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lap_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .d_valid    (d_valid),
      .d_ready    (d_ready),
      .d2x        (d2x),
      .d2y        (d2y),
      .d_meta     (d_meta)
   );

   lap_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .coef_x     (cfg.coef_x),
      .coef_y     (cfg.coef_y),
      .d_valid    (d_valid),
      .d_ready    (d_ready),
      .d2x        (d2x),
      .d2y        (d2y),
      .d_meta     (d_meta),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .laplacian  (laplacian),
      .rsp_meta   (rsp_meta)
   );

   assign rsp_tdata = {rsp_meta.col, rsp_meta.row, laplacian};
   assign rsp_tlast = rsp_meta.last;

`ifndef NO_ASSERTIONS
   // The output register is empty in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // While the receiver is ready, every stage can move and a sample can be taken.
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled although the output is ready");

   // A held difference must block the memory stage from taking a sample.
   a_stall_reaches_input: assert property (@(posedge clock) disable iff (reset)
      (d_valid && !d_ready) |-> !req_tready)
      else $error("sample taken while the line stage is held");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// five_point_laplacian_stencil testbench
// Streams ghost-padded Q16.16 grids through the stencil. A scoreboard keeps
// its own line buffers, window and raster counters and predicts every
// interior Laplacian. It compares each result with the oldest prediction.
// Both sides idle in random bursts, and the receiver holds off once for a
// long time.
// ----------------------------------------------------------------------------
module testbench;
   import lap_pkg::*;

   localparam int GRID_MAX_W    = 256;
   localparam int GRID_MAX_H    = 256;
   localparam int LINE_DEPTH    = GRID_MAX_W + 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 40;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CALM_ITEMS    = 60;

   localparam logic [IDX_W-1:0] CSR_UNMAPPED = 8'hC5;
   localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
   localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

   typedef enum int {MODE_RANDOM, MODE_SMOOTH, MODE_EXTREME} sample_mode_type;

   typedef struct {
      logic [DATA_W-1:0] laplacian;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              last;
   } stencil_point_type;

   class laplacian_scoreboard;
      logic [DIM_W-1:0]  grid_width, grid_height;
      logic [COEF_W-1:0] coef_x, coef_y;
      logic [DATA_W-1:0] line_above [LINE_DEPTH];
      logic [DATA_W-1:0] line_two_above [LINE_DEPTH];
      logic [DATA_W-1:0] centre_tap;
      logic [DIM_W-1:0]  col_pos, row_pos;
      stencil_point_type expected_points [$];
      int                mismatches;
      int                results_checked;

      function new();
         grid_width  = GRID_DIM_RESET;
         grid_height = GRID_DIM_RESET;
         coef_x      = COEF_RESET;
         coef_y      = COEF_RESET;
         foreach (line_above[i]) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
         end
         centre_tap      = '0;
         col_pos         = '0;
         row_pos         = '0;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      function int padded_extent(logic [DIM_W-1:0] dim, int limit);
         if (dim == 0) return 3;
         if (dim > limit) return limit + 2;
         return dim + 2;
      endfunction

      function logic signed [79:0] widen(logic [DATA_W-1:0] v);
         return {{48{v[DATA_W-1]}}, v};
      endfunction

      function void write_reg(logic [IDX_W-1:0] index, logic [DATA_W-1:0] value);
         case (index)
            CSR_GRID_WIDTH:  grid_width  = value[DIM_W-1:0];
            CSR_GRID_HEIGHT: grid_height = value[DIM_W-1:0];
            CSR_COEF_X:      coef_x      = value;
            CSR_COEF_Y:      coef_y      = value;
            default: ;
         endcase
      endfunction

      // Number of samples until the raster counters come back to the origin.
      function int samples_to_frame_end();
         int c, r, pw, ph, n;
         pw = padded_extent(grid_width, GRID_MAX_W);
         ph = padded_extent(grid_height, GRID_MAX_H);
         c  = int'(col_pos);
         r  = int'(row_pos);
         n  = 0;
         do begin
            n++;
            if (c + 1 >= pw) begin
               c = 0;
               r = (r + 1 >= ph) ? 0 : (r + 1) % 512;
            end else begin
               c = (c + 1) % 512;
            end
         end while (!(c == 0 && r == 0));
         return n;
      endfunction

      function void take_sample(logic [DATA_W-1:0] sample);
         int                 pw, ph, c, r;
         logic [DATA_W-1:0]  north, east, centre, west;
         logic signed [79:0] d2x, d2y, acc;
         stencil_point_type  p;
         pw     = padded_extent(grid_width, GRID_MAX_W);
         ph     = padded_extent(grid_height, GRID_MAX_H);
         c      = int'(col_pos);
         r      = int'(row_pos);
         north  = '0;
         east   = '0;
         centre = '0;
         if (c < LINE_DEPTH) begin
            centre = line_above[c];
            north  = line_two_above[c];
         end
         if (c + 1 < LINE_DEPTH) east = line_above[c + 1];
         west       = centre_tap;
         centre_tap = centre;

         if (r >= 2 && r < ph && c >= 1 && c + 2 <= pw) begin
            d2x = widen(east) - 2 * widen(centre) + widen(west);
            d2y = widen(sample) - 2 * widen(centre) + widen(north);
            acc = (d2x * $signed({48'd0, coef_x}) + d2y * $signed({48'd0, coef_y}))
                  >>> FRAC_W;
            if (acc > SAT_HI) acc = SAT_HI;
            else if (acc < SAT_LO) acc = SAT_LO;
            p.laplacian = acc[DATA_W-1:0];
            p.row       = POS_W'(r - 2);
            p.col       = POS_W'(c - 1);
            p.last      = (r == ph - 1) && (c == pw - 2);
            expected_points.push_back(p);
         end

         if (c < LINE_DEPTH) begin
            line_two_above[c] = centre;
            line_above[c]     = sample;
         end
         if (c + 1 >= pw) begin
            col_pos = '0;
            row_pos = (r + 1 >= ph) ? '0 : DIM_W'(r + 1);
         end else begin
            col_pos = DIM_W'(c + 1);
         end
      endfunction

      function void check_result(logic [47:0] data, logic tlast);
         stencil_point_type want;
         results_checked++;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: laplacian %h row %0d col %0d last %b",
                        data[31:0], data[39:32], data[47:40], tlast);
            return;
         end
         want = expected_points.pop_front();
         if (data[31:0] !== want.laplacian || data[39:32] !== want.row ||
             data[47:40] !== want.col || tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected laplacian %h row %0d col %0d last %b, %s",
                        want.laplacian, want.row, want.col, want.last,
                        $sformatf("got laplacian %h row %0d col %0d last %b",
                                  data[31:0], data[39:32], data[47:40], tlast));
         end
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index  = '0;
   logic [DATA_W-1:0]   csr_data   = '0;

   laplacian_scoreboard sb;
   int                  items_sent = 0;
   int                  idle_cycles = 0;
   bit                  src_gaps = 1'b0;
   bit                  sink_gaps = 1'b0;

   five_point_laplacian_stencil #(
      .MAX_WIDTH  (GRID_MAX_W),
      .MAX_HEIGHT (GRID_MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] pick_sample(sample_mode_type mode);
      logic [19:0] small_value;
      small_value = 20'($urandom);
      case (mode)
         MODE_SMOOTH: return {{12{small_value[19]}}, small_value};
         MODE_EXTREME: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return COEF_RESET;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return COEF_RESET;
         3: return $urandom;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   // Dimension registers only keep their low bits, so the rest carries noise.
   function automatic logic [DATA_W-1:0] dim_word(logic [DIM_W-1:0] dim);
      logic [DATA_W-1:0] word;
      word = $urandom;
      word[DIM_W-1:0] = dim;
      return word;
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic write_csr(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [DATA_W-1:0] width, input logic [DATA_W-1:0] height,
                            input logic [COEF_W-1:0] cx, input logic [COEF_W-1:0] cy);
      write_csr(CSR_GRID_WIDTH, width);
      write_csr(CSR_GRID_HEIGHT, height);
      write_csr(CSR_COEF_X, cx);
      write_csr(CSR_COEF_Y, cy);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic [DATA_W-1:0] value);
      int gap;
      if (src_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_sample(value);
      @(negedge clock);
   endtask

   task automatic stream(input int count, input sample_mode_type mode);
      for (int i = 0; i < count; i++) send_sample(pick_sample(mode));
      items_sent += count;
   endtask

   // Stop offering samples, wait for every predicted result, then let the
   // pipeline run dry.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("five_point_laplacian_stencil test failed");
            $finish;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off so that the
   // block fills up and pushes back on the sample stream.
   initial begin
      bit held;
      int gap;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sb.results_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid) sb.check_result(rsp_tdata, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin
      logic [DATA_W-1:0] corner_cases [2][9];
      int                goal;
      int                count;
      sb = new();
      // Padded 3x3 frames in raster order: ghost, north, ghost / west, centre,
      // east / ghost, south, ghost.
      corner_cases = '{
         '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
           32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
         '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
           32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001,
           32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-point frames at the sample limits: the first saturates high
      // with the largest coefficients, the second rounds a large negative
      // sum toward minus infinity with a tiny y coefficient.
      for (int f = 0; f < 2; f++) begin
         settle();
         if (f == 0) begin
            configure(32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         end else begin
            write_csr(CSR_UNMAPPED, $urandom);
            configure(32'd1, 32'd1, 32'h0000_0000, 32'h0000_0001);
         end
         for (int k = 0; k < 9; k++) send_sample(corner_cases[f][k]);
      end

      // Width above the maximum and height zero: one full-width row. This
      // also fills every entry of both line buffers.
      settle();
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      configure(32'hFFFF_FFFF, 32'h5A5A_5E00, 32'h0000_8000, COEF_RESET);
      stream(sb.samples_to_frame_end(), MODE_SMOOTH);

      // Width zero and a tall grid.
      settle();
      configure(32'h0000_0000, 32'd100, pick_coef(), pick_coef());
      stream(sb.samples_to_frame_end(), MODE_EXTREME);

      // Random small grids; some phases stop mid-frame and may change the
      // geometry before the frame resumes.
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         if (items_sent >= goal - CALM_ITEMS) begin
            src_gaps  = 1'b0;
            sink_gaps = 1'b0;
         end else begin
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 9) < 7) begin
            settle();
            if ($urandom_range(0, 3) != 0)
               case ($urandom_range(0, 9))
                  0: write_csr(CSR_GRID_WIDTH, dim_word('0));
                  1: write_csr(CSR_GRID_WIDTH, dim_word(DIM_W'($urandom_range(9, 24))));
                  default: write_csr(CSR_GRID_WIDTH, dim_word(DIM_W'($urandom_range(1, 8))));
               endcase
            if ($urandom_range(0, 3) != 0)
               case ($urandom_range(0, 9))
                  0: write_csr(CSR_GRID_HEIGHT, dim_word('0));
                  default: write_csr(CSR_GRID_HEIGHT, dim_word(DIM_W'($urandom_range(1, 4))));
               endcase
            if ($urandom_range(0, 3) != 0) write_csr(CSR_COEF_X, pick_coef());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_COEF_Y, pick_coef());
            if ($urandom_range(0, 15) == 0)
               write_csr(IDX_W'($urandom_range(CSR_COEF_Y + 1, 2 ** IDX_W - 1)), $urandom);
            csr_valid <= 1'b0;
         end
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 25);
         else count = sb.samples_to_frame_end();
         stream(count, sample_mode_type'($urandom_range(0, 2)));
      end

      settle();
      if (sb.mismatches == 0) begin
         $display("five_point_laplacian_stencil test passed");
      end else begin
         $display("five_point_laplacian_stencil test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lap_pkg.sv
rtl/lap_csr.sv
rtl/lap_line_buf.sv
rtl/lap_scale.sv
rtl/five_point_laplacian_stencil.sv
tb/sv/testbench.sv
